@@ hw/rtl/sctb_pkg.sv @@
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared widths, codes and the slot entry type of the timer bank.
// ----------------------------------------------------------------------------
package sctb_pkg;

  localparam int SLOTS_DEF = 4;

  localparam int MODE_W    = 2;
  localparam int ELAPSED_W = 16;
  localparam int DUR_W     = 32;
  localparam int SIDX_W    = 4;
  localparam int OCC_W     = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             act;
    logic [DUR_W-1:0] rem;
  } entry_t;

endpackage

@@ hw/rtl/sctb_if.sv @@
// ----------------------------------------------------------------------------
// Countdown timer bank channels
// Valid/ready channels for command words and status words.
// ----------------------------------------------------------------------------
interface sctb_in_if;
  import sctb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DUR_W-1:0]     duration;
  logic [SIDX_W-1:0]    slot_index;

  modport source (output valid, output mode, output elapsed, output duration,
                  output slot_index, input ready);
  modport sink   (input valid, input mode, input elapsed, input duration,
                  input slot_index, output ready);
endinterface

interface sctb_out_if;
  import sctb_pkg::*;

  logic             valid;
  logic             ready;
  logic             fired;
  logic             accepted;
  logic             bank_full;
  logic             bank_empty;
  logic [OCC_W-1:0] occupied;

  modport source (output valid, output fired, output accepted, output bank_full,
                  output bank_empty, output occupied, input ready);
  modport sink   (input valid, input fired, input accepted, input bank_full,
                  input bank_empty, input occupied, output ready);
endinterface

@@ hw/rtl/sctb_mem.sv @@
// ----------------------------------------------------------------------------
// Countdown timer bank slot memory
// One-port-read, one-port-write slot store with registered read data.
// Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module sctb_mem #(
  parameter int SLOTS = sctb_pkg::SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output sctb_pkg::entry_t  rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  sctb_pkg::entry_t  wr_data_i
);
  import sctb_pkg::*;

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  entry_t           rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

@@ hw/rtl/sctb_walk.sv @@
// ----------------------------------------------------------------------------
// Countdown timer bank slot walker
// Walks the slot memory once per tick, insert or remove word, reading one slot
// per cycle and writing it back updated; holds the status word until taken.
// ----------------------------------------------------------------------------
module sctb_walk #(
  parameter int SLOTS = sctb_pkg::SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sctb_in_if.sink           in_i,
  sctb_out_if.source        out_o,
  output logic              rd_en_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  sctb_pkg::entry_t  rd_data_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output sctb_pkg::entry_t  wr_data_o
);
  import sctb_pkg::*;

  localparam int K_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  state_e               state_q, state_d;
  logic [K_W-1:0]       rk_q, rk_d;
  logic                 dv_q, dv_d;
  logic [IDX_W-1:0]     dk_q, dk_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [SIDX_W-1:0]    idx_q, idx_d;
  logic [DUR_W-1:0]     v_q, v_d;
  logic                 acc_q, acc_d;
  logic                 fired_q, fired_d;
  logic                 stop_q, stop_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     occ_q, occ_d;

  logic                 ovalid_q, ovalid_d;
  logic                 ofired_q, ofired_d;
  logic                 oacc_q, oacc_d;
  logic                 ofull_q, ofull_d;
  logic                 oempty_q, oempty_d;
  logic [OCC_W-1:0]     oocc_q, oocc_d;

  logic [DUR_W-1:0]     rem;
  logic [DUR_W-1:0]     ela_ext;
  logic [DUR_W-1:0]     mx;
  logic [DUR_W-1:0]     mn;
  logic [SIDX_W:0]      dk_ext;
  logic [SIDX_W:0]      idx_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rk_q     <= '0;
      dv_q     <= 1'b0;
      dk_q     <= '0;
      acc_q    <= 1'b0;
      fired_q  <= 1'b0;
      stop_q   <= 1'b0;
      cnt_q    <= '0;
      occ_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rk_q     <= rk_d;
      dv_q     <= dv_d;
      dk_q     <= dk_d;
      acc_q    <= acc_d;
      fired_q  <= fired_d;
      stop_q   <= stop_d;
      cnt_q    <= cnt_d;
      occ_q    <= occ_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    elapsed_q <= elapsed_d;
    idx_q     <= idx_d;
    v_q       <= v_d;
    ofired_q  <= ofired_d;
    oacc_q    <= oacc_d;
    ofull_q   <= ofull_d;
    oempty_q  <= oempty_d;
    oocc_q    <= oocc_d;
  end

  assign rem     = rd_data_i.rem;
  assign ela_ext = DUR_W'(elapsed_q);
  assign mx      = (rem < v_q) ? v_q : rem;
  assign mn      = (rem < v_q) ? rem : v_q;
  assign dk_ext  = (SIDX_W + 1)'(dk_q);
  assign idx_ext = {1'b0, idx_q};

  always_comb begin
    state_d   = state_q;
    rk_d      = rk_q;
    dv_d      = 1'b0;
    dk_d      = dk_q;
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    idx_d     = idx_q;
    v_d       = v_q;
    acc_d     = acc_q;
    fired_d   = fired_q;
    stop_d    = stop_q;
    cnt_d     = cnt_q;
    occ_d     = occ_q;
    ovalid_d  = ovalid_q;
    ofired_d  = ofired_q;
    oacc_d    = oacc_q;
    ofull_d   = ofull_q;
    oempty_d  = oempty_q;
    oocc_d    = oocc_q;
    rd_en_o   = 1'b0;
    rd_addr_o = rk_q[IDX_W-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = dk_q;
    wr_data_o = '0;
    in_i.ready = 1'b0;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mode_d    = in_i.mode;
          elapsed_d = in_i.elapsed;
          idx_d     = in_i.slot_index;
          fired_d   = 1'b0;
          stop_d    = 1'b0;
          cnt_d     = '0;
          rk_d      = '0;
          acc_d     = 1'b0;
          v_d       = '0;
          state_d   = ST_WALK;
          case (in_i.mode)
            MODE_TICK: begin
            end
            MODE_INSERT: begin
              acc_d = (in_i.duration != '0) && (occ_q < CNT_W'(SLOTS));
              v_d   = acc_d ? in_i.duration : '0;
            end
            MODE_REMOVE: begin
              acc_d = {1'b0, in_i.slot_index} < (SIDX_W + 1)'(SLOTS);
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (rk_q < K_W'(SLOTS)) begin
          rd_en_o = 1'b1;
          rk_d    = rk_q + K_W'(1);
          dv_d    = 1'b1;
          dk_d    = rk_q[IDX_W-1:0];
        end
        if (dv_q) begin
          case (mode_q)
            MODE_TICK: begin
              if (!stop_q && rd_data_i.act) begin
                wr_en_o = 1'b1;
                if (rem != '0) begin
                  wr_data_o.act = 1'b1;
                  wr_data_o.rem = (rem > ela_ext) ? rem - ela_ext : '0;
                end else begin
                  fired_d = 1'b1;
                  stop_d  = 1'b1;
                end
              end
            end
            MODE_INSERT: begin
              // The slots stay in descending order, so one merge pass sorts.
              wr_en_o       = 1'b1;
              wr_data_o.act = (mx != '0);
              wr_data_o.rem = mx;
              v_d           = mn;
              cnt_d         = cnt_q + CNT_W'(mx != '0);
            end
            default: begin
              // Remove: the slots after the cleared one move up by one place.
              wr_data_o.act = (rem != '0);
              wr_data_o.rem = rem;
              if (acc_q && dk_ext == idx_ext) begin
                wr_en_o = 1'b0;
              end else begin
                wr_en_o = 1'b1;
                cnt_d   = cnt_q + CNT_W'(rem != '0);
                if (acc_q && dk_ext > idx_ext) begin
                  wr_addr_o = dk_q - IDX_W'(1);
                end
              end
            end
          endcase
          if (dk_q == LAST) begin
            if (mode_q == MODE_TICK) begin
              occ_d = occ_q - CNT_W'(fired_d);
            end else begin
              occ_d = cnt_d;
            end
            state_d = (mode_q == MODE_REMOVE && acc_q) ? ST_FLUSH : ST_DONE;
          end
        end
      end

      ST_FLUSH: begin
        wr_en_o   = 1'b1;
        wr_addr_o = LAST;
        wr_data_o = '0;
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          ofired_d = fired_q;
          oacc_d   = acc_q;
          ofull_d  = (occ_q == CNT_W'(SLOTS));
          oempty_d = (occ_q == '0);
          oocc_d   = OCC_W'(occ_q);
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.fired      = ofired_q;
  assign out_o.accepted   = oacc_q;
  assign out_o.bank_full  = ofull_q;
  assign out_o.bank_empty = oempty_q;
  assign out_o.occupied   = oocc_q;

endmodule

@@ hw/rtl/sorted_countdown_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// Sorted countdown timer bank
// A bank of SLOTS one-shot countdown timers kept in descending order.
// ----------------------------------------------------------------------------
// The command channel in_i takes one word per tick, insert or remove request.
// The status channel out_o returns exactly one word per command word, with
// the fired and accepted flags and the bank occupancy after the command.
// The slots live in a small memory with one read and one write port. Each
// tick, insert or remove command walks the memory one slot per cycle, reading a
// slot and writing the updated slot back in the following cycle.
// An accepted remove ends with a flush write that clears the last slot; the
// unused mode skips the walk. One command is in flight at a time; the memory
// walk sets the rate.
// A status word waits in an output register, and the next command word is
// taken while it waits. If the receiver stalls, a finished command holds until
// the register is free, and no further command word is taken meanwhile.
// After reset every slot reads as empty and inactive, with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_countdown_timer_bank_top #(
  parameter int SLOTS = sctb_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sctb_in_if.sink     in_i,
  sctb_out_if.source  out_o
);
  import sctb_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  sctb_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  sctb_walk #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted countdown timer bank testbench
// Drives tick, insert, remove and unused-mode command words into the bank,
// predicts every status word from a model of the slots in this file, and
// compares each status word field by field. Directed cases come first, then
// a long receiver stall, then random traffic under three idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import sctb_pkg::*;

  localparam int BANK_SLOTS = SLOTS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 540;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [ELAPSED_W-1:0] elapsed;
    logic [DUR_W-1:0]     duration;
    logic [SIDX_W-1:0]    slot_index;
  } timer_cmd_t;

  typedef struct packed {
    logic             fired;
    logic             accepted;
    logic             bank_full;
    logic             bank_empty;
    logic [OCC_W-1:0] occupied;
  } bank_status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sctb_in_if  cmd_if ();
  sctb_out_if sts_if ();

  sorted_countdown_timer_bank_top #(
    .SLOTS(BANK_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (sts_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  entry_t       timer_slots [BANK_SLOTS];
  bank_status_t pending_status [$];

  int send_idle_pct;
  int recv_idle_pct;
  int ready_hold_cycles;
  int words_sent;
  int status_words_seen;
  int status_errors;
  int stray_words;
  int fired_seen;
  int accepted_seen;
  int full_seen;

  function automatic int slots_in_use();
    int n;
    n = 0;
    for (int k = 0; k < BANK_SLOTS; k++) begin
      n += timer_slots[k].act;
    end
    return n;
  endfunction

  function automatic void resort_slots();
    entry_t t;
    for (int p = 0; p < BANK_SLOTS; p++) begin
      for (int k = 0; k + 1 < BANK_SLOTS; k++) begin
        if (timer_slots[k].rem < timer_slots[k+1].rem) begin
          t = timer_slots[k];
          timer_slots[k] = timer_slots[k+1];
          timer_slots[k+1] = t;
        end
      end
    end
    for (int k = 0; k < BANK_SLOTS; k++) begin
      timer_slots[k].act = (timer_slots[k].rem != '0);
    end
  endfunction

  function automatic bank_status_t apply_timer_cmd(timer_cmd_t c);
    bank_status_t s;
    logic         done;
    int           occ;
    s = '0;
    done = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        for (int k = 0; k < BANK_SLOTS; k++) begin
          if (!done && timer_slots[k].act) begin
            if (timer_slots[k].rem != '0) begin
              timer_slots[k].rem = (timer_slots[k].rem > c.elapsed) ?
                                   timer_slots[k].rem - c.elapsed : '0;
            end else begin
              timer_slots[k].act = 1'b0;
              s.fired = 1'b1;
              done = 1'b1;
            end
          end
        end
      end
      MODE_INSERT: begin
        if (c.duration != '0 && slots_in_use() < BANK_SLOTS) begin
          for (int k = 0; k < BANK_SLOTS; k++) begin
            if (!done && !timer_slots[k].act) begin
              timer_slots[k].rem = c.duration;
              timer_slots[k].act = 1'b1;
              s.accepted = 1'b1;
              done = 1'b1;
            end
          end
        end
        resort_slots();
      end
      MODE_REMOVE: begin
        if (c.slot_index < BANK_SLOTS) begin
          timer_slots[c.slot_index].rem = '0;
          timer_slots[c.slot_index].act = 1'b0;
          s.accepted = 1'b1;
        end
        resort_slots();
      end
      default: begin
      end
    endcase
    occ = slots_in_use();
    s.bank_full  = (occ == BANK_SLOTS);
    s.bank_empty = (occ == 0);
    s.occupied   = OCC_W'(occ);
    return s;
  endfunction

  task automatic send_word(input timer_cmd_t c);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.mode       <= c.mode;
    cmd_if.elapsed    <= c.elapsed;
    cmd_if.duration   <= c.duration;
    cmd_if.slot_index <= c.slot_index;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_status.push_back(apply_timer_cmd(c));
    words_sent++;
  endtask

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [ELAPSED_W-1:0] elapsed,
                          input logic [DUR_W-1:0] duration,
                          input logic [SIDX_W-1:0] slot_index);
    timer_cmd_t c;
    c.mode       = mode;
    c.elapsed    = elapsed;
    c.duration   = duration;
    c.slot_index = slot_index;
    send_word(c);
  endtask

  task automatic drain_status();
    cmd_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 20) return $urandom;
    return $urandom_range(400, 1);
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '1;
    if (r < 15) return ELAPSED_W'($urandom);
    if (r < 25) return '0;
    return ELAPSED_W'($urandom_range(120, 1));
  endfunction

  task automatic test_directed_cases();
    send_cmd(MODE_TICK, '0, '0, '0);
    send_cmd(MODE_UNUSED, '1, '1, '1);
    send_cmd(MODE_REMOVE, '0, '0, 4'd0);
    send_cmd(MODE_REMOVE, '0, '0, 4'd15);
    send_cmd(MODE_INSERT, '0, '0, '0);
    send_cmd(MODE_INSERT, '0, 32'hFFFF_FFFF, '0);
    send_cmd(MODE_INSERT, '0, 32'd1, '0);
    send_cmd(MODE_INSERT, '0, 32'd5, '0);
    send_cmd(MODE_INSERT, '0, 32'h8000_0000, '0);
    send_cmd(MODE_INSERT, '0, 32'd9, '0);
    send_cmd(MODE_UNUSED, '0, '0, '0);
    send_cmd(MODE_TICK, 16'hFFFF, '0, '0);
    send_cmd(MODE_TICK, '0, '0, '0);
    send_cmd(MODE_TICK, '0, '0, '0);
    send_cmd(MODE_INSERT, '0, 32'd7, '0);
    send_cmd(MODE_TICK, 16'd10, '0, '0);
    send_cmd(MODE_REMOVE, '0, '0, 4'(BANK_SLOTS));
    send_cmd(MODE_REMOVE, '0, '0, 4'd0);
    send_cmd(MODE_INSERT, '0, 32'd3, '0);
    send_cmd(MODE_TICK, 16'd3, '0, '0);
    send_cmd(MODE_TICK, 16'd1, '0, '0);
    send_cmd(MODE_TICK, 16'd1, '0, '0);
    send_cmd(MODE_REMOVE, '0, '0, 4'd1);
    send_cmd(MODE_REMOVE, '0, '0, 4'd0);
    drain_status();
  endtask

  task automatic test_output_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    ready_hold_cycles = 80;
    for (int n = 0; n < 10; n++) begin
      if (n % 3 == 2) begin
        send_cmd(MODE_TICK, pick_elapsed(), '0, '0);
      end else begin
        send_cmd(MODE_INSERT, '0, pick_duration(), '0);
      end
    end
    drain_status();
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_traffic(input int word_count);
    int   stop_at;
    int   k;
    timer_cmd_t c;
    stop_at = words_sent + word_count;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(BANK_SLOTS + 1, 1);
        repeat (k) send_cmd(MODE_INSERT, '0, pick_duration(), '0);
        k = $urandom_range(12, 2);
        repeat (k) send_cmd(MODE_TICK, pick_elapsed(), '0, '0);
        if ($urandom_range(3) == 0) begin
          send_cmd(MODE_REMOVE, '0, '0, SIDX_W'($urandom_range(BANK_SLOTS - 1)));
        end
      end else begin
        c.mode       = MODE_W'($urandom_range(3));
        c.elapsed    = ELAPSED_W'($urandom);
        c.duration   = ($urandom_range(1) == 0) ? DUR_W'($urandom) : pick_duration();
        c.slot_index = SIDX_W'($urandom);
        send_word(c);
      end
    end
  endtask

  task automatic check_status(input bank_status_t got);
    bank_status_t want;
    if (pending_status.size() == 0) begin
      stray_words++;
      if (stray_words + status_errors <= 10) begin
        $display("Status word %0d arrived with no command waiting for it.",
                 status_words_seen);
      end
    end else begin
      want = pending_status.pop_front();
      if (got.fired !== want.fired || got.accepted !== want.accepted ||
          got.bank_full !== want.bank_full || got.bank_empty !== want.bank_empty ||
          got.occupied !== want.occupied) begin
        status_errors++;
        if (stray_words + status_errors <= 10) begin
          $display("Status word %0d: expected fired=%0b accepted=%0b full=%0b ",
                   status_words_seen, want.fired, want.accepted, want.bank_full,
                   "empty=%0b occ=%0d, got fired=%0b accepted=%0b full=%0b ",
                   want.bank_empty, want.occupied, got.fired, got.accepted,
                   got.bank_full, "empty=%0b occ=%0d.", got.bank_empty,
                   got.occupied);
        end
      end
    end
    fired_seen    += got.fired;
    accepted_seen += got.accepted;
    full_seen     += got.bank_full;
    status_words_seen++;
  endtask

  initial begin
    sts_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && sts_if.valid && sts_if.ready) begin
        check_status({sts_if.fired, sts_if.accepted, sts_if.bank_full,
                      sts_if.bank_empty, sts_if.occupied});
      end
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        sts_if.ready <= 1'b0;
      end else begin
        sts_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int waited;
    rst_ni = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.mode       = '0;
    cmd_if.elapsed    = '0;
    cmd_if.duration   = '0;
    cmd_if.slot_index = '0;
    for (int k = 0; k < BANK_SLOTS; k++) timer_slots[k] = '0;
    send_idle_pct     = 31;
    recv_idle_pct     = 62;
    ready_hold_cycles = 0;
    words_sent        = 0;
    status_words_seen = 0;
    status_errors     = 0;
    stray_words       = 0;
    fired_seen        = 0;
    accepted_seen     = 0;
    full_seen         = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_output_backpressure();
    test_random_traffic(WORDS_PER_PHASE);
    drain_status();
    send_idle_pct = 62;
    recv_idle_pct = 31;
    test_random_traffic(WORDS_PER_PHASE);
    drain_status();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(WORDS_PER_PHASE);

    cmd_if.valid <= 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * BANK_SLOTS + 8) @(posedge clk_i);

    $display("Sent %0d command words and checked %0d status words.", words_sent,
             status_words_seen);
    $display("Timers fired %0d times, %0d commands were accepted, bank full %0d times.",
             fired_seen, accepted_seen, full_seen);
    if (status_errors == 0 && stray_words == 0 && pending_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d wrong, %0d unexpected and %0d missing status words.", status_errors,
               stray_words, pending_status.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Run stopped after the time limit with %0d status words outstanding.",
             pending_status.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
